// ===== hdl/drrip_pkg.sv =====
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared types and constants for the DRRIP replacement policy block.
// ----------------------------------------------------------------------------
package drrip_pkg;

  // default configuration
  localparam int DEF_NUM_SETS           = 1024;
  localparam int DEF_NUM_WAYS           = 16;
  localparam int DEF_DEDICATED_PER_1024 = 32;
  localparam int DEF_SELECTOR_MAX       = 1024;
  localparam int DEF_BIP_PERIOD         = 32;

  // fixed field widths
  localparam int REQ_W      = 3;
  localparam int SET_IDX_W  = 10;
  localparam int WAY_IDX_W  = 4;
  localparam int WAY_EXT_W  = 5;
  localparam int VICTIM_W   = 4;
  localparam int RANK_OUT_W = 5;

  // re-reference values
  localparam logic [1:0] RRPV_NEAR   = 2'd3;
  localparam logic [1:0] RRPV_LONG   = 2'd1;
  localparam logic [1:0] RRPV_DISTANT = 2'd0;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_HIT    = 3'd0,
    REQ_MISS   = 3'd1,
    REQ_VICTIM = 3'd2,
    REQ_FILL   = 3'd3,
    REQ_RANK   = 3'd4
  } req_code_t;

  // row operation handed to the row update logic
  typedef struct packed {
    req_code_t              code;
    logic [WAY_EXT_W-1:0]   way;
    logic                   way_ok;
    logic [1:0]             ins_val;
  } row_op_t;

endpackage

// ===== hdl/drrip_row_upd.sv =====
// ----------------------------------------------------------------------------
// drrip_row_upd
// Modifies one set row of re-reference values and fill-order ranks for a
// request and forms the result fields.
// ----------------------------------------------------------------------------
module drrip_row_upd import drrip_pkg::*; #(
  parameter int NUM_WAYS = DEF_NUM_WAYS
) (
  input  row_op_t                                      op,
  input  logic [NUM_WAYS*2-1:0]                        rrpv_row,
  input  logic [NUM_WAYS*$clog2(NUM_WAYS+1)-1:0]       rank_row,
  output logic [NUM_WAYS*2-1:0]                        rrpv_new,
  output logic [NUM_WAYS*$clog2(NUM_WAYS+1)-1:0]       rank_new,
  output logic [VICTIM_W-1:0]                          victim_way,
  output logic [RANK_OUT_W-1:0]                        fill_rank
);

  localparam int RANK_W = $clog2(NUM_WAYS+1);

  logic [1:0]        rrpv_min;
  logic              any0, any1, any2;
  logic [RANK_W-1:0] mine;
  logic              found;
  logic [VICTIM_W-1:0] victim_sel;

  // smallest value in the row and rank of the addressed way
  always_comb begin
    any0 = 1'b0;
    any1 = 1'b0;
    any2 = 1'b0;
    mine = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      any0 = any0 | (rrpv_row[2*i +: 2] == 2'd0);
      any1 = any1 | (rrpv_row[2*i +: 2] == 2'd1);
      any2 = any2 | (rrpv_row[2*i +: 2] == 2'd2);
      if (op.way == WAY_EXT_W'(i)) begin
        mine = mine | rank_row[RANK_W*i +: RANK_W];
      end
    end
    if (any0) begin
      rrpv_min = 2'd0;
    end else if (any1) begin
      rrpv_min = 2'd1;
    end else if (any2) begin
      rrpv_min = 2'd2;
    end else begin
      rrpv_min = 2'd3;
    end
  end

  // lowest way holding the minimum becomes the victim after aging
  always_comb begin
    found      = 1'b0;
    victim_sel = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!found && rrpv_row[2*i +: 2] == rrpv_min) begin
        found      = 1'b1;
        victim_sel = VICTIM_W'(i);
      end
    end
  end

  // row modification per request
  always_comb begin
    rrpv_new   = rrpv_row;
    rank_new   = rank_row;
    victim_way = '0;
    fill_rank  = '0;
    unique case (op.code)
      REQ_HIT: begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (op.way_ok && op.way == WAY_EXT_W'(i)) begin
            rrpv_new[2*i +: 2] = RRPV_NEAR;
          end
        end
      end
      REQ_VICTIM: begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          rrpv_new[2*i +: 2] = rrpv_row[2*i +: 2] - rrpv_min;
        end
        victim_way = victim_sel;
      end
      REQ_FILL: begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (op.way_ok) begin
            if (op.way == WAY_EXT_W'(i)) begin
              rrpv_new[2*i +: 2]          = op.ins_val;
              rank_new[RANK_W*i +: RANK_W] = '0;
            end else if (rank_row[RANK_W*i +: RANK_W] < mine) begin
              rank_new[RANK_W*i +: RANK_W] = rank_row[RANK_W*i +: RANK_W] + 1'b1;
            end
          end
        end
      end
      REQ_RANK: begin
        fill_rank = op.way_ok ? RANK_OUT_W'(mine) : RANK_OUT_W'(NUM_WAYS);
      end
      default: begin
        rrpv_new = rrpv_row;
      end
    endcase
  end

endmodule

// ===== hdl/drrip_replacement_policy.sv =====
// ----------------------------------------------------------------------------
// drrip_replacement_policy
// Dynamic RRIP replacement with set dueling: per-way 2-bit re-reference
// values, per-set fill-order ranks, a saturating duel selector and a BIP
// insertion counter.
// ----------------------------------------------------------------------------
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ------------------
//  request   in_req_type, in_set_index, in_way_index      start && !busy
//  result    out_victim_way, out_fill_rank                out_valid strobe
//
// On the accepting edge a request reads the set row from the row memories into
// registers; in the EXEC state that follows, the row is modified and written
// back while the result is registered. After reset a clearing pass writes
// one row per cycle over all NUM_SETS rows, with busy held high. Results are
// strobed for one cycle and cannot be stalled; a new request may be accepted
// in the cycle its result shows.
//
module drrip_replacement_policy import drrip_pkg::*; #(
  parameter int NUM_SETS           = DEF_NUM_SETS,
  parameter int NUM_WAYS           = DEF_NUM_WAYS,
  parameter int DEDICATED_PER_1024 = DEF_DEDICATED_PER_1024,
  parameter int SELECTOR_MAX       = DEF_SELECTOR_MAX,
  parameter int BIP_PERIOD         = DEF_BIP_PERIOD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [SET_IDX_W-1:0]  in_set_index,
  input  logic [WAY_IDX_W-1:0]  in_way_index,
  output logic                  out_valid,
  output logic [VICTIM_W-1:0]   out_victim_way,
  output logic [RANK_OUT_W-1:0] out_fill_rank
);

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int RANK_W  = $clog2(NUM_WAYS+1);
  localparam int SEL_W   = $clog2(SELECTOR_MAX);
  localparam int BIP_W   = $clog2(BIP_PERIOD);
  localparam int GROUP   = 1024 / DEDICATED_PER_1024;
  localparam int GSHIFT  = $clog2(GROUP+1) - 1;
  localparam logic [SET_IDX_W-1:0] GMASK = SET_IDX_W'(GROUP - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                       state_r;
  logic [SET_W-1:0]             clr_r;
  logic [SEL_W-1:0]             sel_r;
  logic [BIP_W-1:0]             bip_r;
  logic [REQ_W-1:0]             req_r;
  logic [SET_IDX_W-1:0]         set_r;
  logic [WAY_IDX_W-1:0]         way_r;
  logic                         out_valid_r;
  logic [VICTIM_W-1:0]          victim_r;
  logic [RANK_OUT_W-1:0]        rank_out_r;

  // row memories
  logic [NUM_WAYS*2-1:0]        rrpv_mem [NUM_SETS];
  logic [NUM_WAYS*RANK_W-1:0]   rank_mem [NUM_SETS];
  logic [NUM_WAYS*2-1:0]        rrpv_rd_r;
  logic [NUM_WAYS*RANK_W-1:0]   rank_rd_r;

  logic                         accept;
  logic                         srrip_set, brrip_set;
  logic [SET_IDX_W-1:0]         set_hi;
  logic [1:0]                   brrip_val;
  row_op_t                      op;
  logic [NUM_WAYS*2-1:0]        rrpv_new;
  logic [NUM_WAYS*RANK_W-1:0]   rank_new;
  logic [VICTIM_W-1:0]          victim_calc;
  logic [RANK_OUT_W-1:0]        rank_calc;
  logic                         wr_en;
  logic [SET_W-1:0]             wr_addr;
  logic [NUM_WAYS*2-1:0]        wr_rrpv;
  logic [NUM_WAYS*RANK_W-1:0]   wr_rank;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // set classification of the request in flight
  assign set_hi    = (set_r >> GSHIFT) & GMASK;
  assign srrip_set = (set_r & GMASK) == set_hi;
  assign brrip_set = !srrip_set && ((~set_r & GMASK) == set_hi);
  assign brrip_val = (bip_r == '0) ? RRPV_LONG : RRPV_DISTANT;

  // row operation for the update logic
  always_comb begin
    op.code   = req_code_t'(req_r);
    op.way    = WAY_EXT_W'(way_r);
    op.way_ok = int'(way_r) < NUM_WAYS;
    priority if (srrip_set) begin
      op.ins_val = RRPV_LONG;
    end else if (brrip_set) begin
      op.ins_val = brrip_val;
    end else if (sel_r >= SEL_W'(SELECTOR_MAX / 2)) begin
      op.ins_val = brrip_val;
    end else begin
      op.ins_val = RRPV_LONG;
    end
  end

  drrip_row_upd #(
    .NUM_WAYS (NUM_WAYS)
  ) u_row_upd (
    .op         (op),
    .rrpv_row   (rrpv_rd_r),
    .rank_row   (rank_rd_r),
    .rrpv_new   (rrpv_new),
    .rank_new   (rank_new),
    .victim_way (victim_calc),
    .fill_rank  (rank_calc)
  );

  // write port: clearing pass or write-back of the modified row
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SET_W'(set_r);
    wr_rrpv = rrpv_new;
    wr_rank = rank_new;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_rrpv = '0;
      wr_rank = {NUM_WAYS{RANK_W'(NUM_WAYS)}};
    end else if (state_r == ST_EXEC) begin
      wr_en = (op.code == REQ_HIT) || (op.code == REQ_VICTIM) || (op.code == REQ_FILL);
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rrpv_mem[wr_addr] <= wr_rrpv;
      rank_mem[wr_addr] <= wr_rank;
    end
    if (accept) begin
      rrpv_rd_r <= rrpv_mem[SET_W'(in_set_index)];
      rank_rd_r <= rank_mem[SET_W'(in_set_index)];
    end
  end

  // request registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      set_r <= in_set_index;
      way_r <= in_way_index;
    end
  end

  // control state, selector, bip counter and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      sel_r       <= SEL_W'(SELECTOR_MAX / 2);
      bip_r       <= '0;
      out_valid_r <= 1'b0;
      victim_r    <= '0;
      rank_out_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SET_W'(NUM_SETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          victim_r    <= victim_calc;
          rank_out_r  <= rank_calc;
          // duel selector moves on misses in sample sets
          if (op.code == REQ_MISS) begin
            if (srrip_set && sel_r < SEL_W'(SELECTOR_MAX - 1)) begin
              sel_r <= sel_r + 1'b1;
            end else if (brrip_set && sel_r != '0) begin
              sel_r <= sel_r - 1'b1;
            end
          end
          // bip counter advances on every valid fill
          if (op.code == REQ_FILL && op.way_ok) begin
            if (bip_r >= BIP_W'(BIP_PERIOD - 1)) begin
              bip_r <= '0;
            end else begin
              bip_r <= bip_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = victim_r;
  assign out_fill_rank  = rank_out_r;

endmodule

// ===== test/drrip_replacement_policy_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drrip_replacement_policy_tb
// Self-checking bench for the DRRIP replacement block. Requests go in through
// the start/busy command port. A shadow copy of the re-reference values,
// fill-order ranks, duel selector and BIP counter is updated on every
// accepted request. Each strobed result is compared with the oldest
// outstanding expectation. A short directed run is followed by a long random
// run that pushes the selector to both of its limits.
// ----------------------------------------------------------------------------
module drrip_replacement_policy_tb import drrip_pkg::*;;

  localparam int NUM_SETS     = DEF_NUM_SETS;
  localparam int NUM_WAYS     = DEF_NUM_WAYS;
  localparam int SELECTOR_MAX = DEF_SELECTOR_MAX;
  localparam int BIP_PERIOD   = DEF_BIP_PERIOD;
  localparam int GROUP        = 1024 / DEF_DEDICATED_PER_1024;
  localparam int GROUP_SHIFT  = $clog2(GROUP);
  localparam logic [SET_IDX_W-1:0] GROUP_MASK = SET_IDX_W'(GROUP - 1);

  localparam int RANDOM_ITEMS = 1700;
  localparam int RANDOM_CAP   = 4000;
  localparam int MAX_GAP      = 18;
  localparam int TAIL_CYCLES  = 10;
  localparam int LIMIT_CYCLES = 400000;

  typedef enum int {SET_FOLLOWER, SET_SRRIP, SET_BRRIP} set_kind_t;

  typedef struct {
    logic [REQ_W-1:0]      code;
    logic [VICTIM_W-1:0]   victim;
    logic [RANK_OUT_W-1:0] rank;
  } outcome_t;

  // shadow of the replacement state plus the queue of outcomes still owed
  class replacement_scoreboard;
    logic [1:0]            rrpv_mem [NUM_SETS*NUM_WAYS];
    logic [RANK_OUT_W-1:0] rank_mem [NUM_SETS*NUM_WAYS];
    int unsigned           selector;
    int unsigned           bip_count;
    logic [VICTIM_W-1:0]   last_victim;
    int unsigned           mismatches;
    outcome_t              owed_outcomes [$];

    function new();
      for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
        rrpv_mem[i] = RRPV_DISTANT;
        rank_mem[i] = RANK_OUT_W'(NUM_WAYS);
      end
      selector    = SELECTOR_MAX / 2;
      bip_count   = 0;
      last_victim = '0;
      mismatches  = 0;
    endfunction

    function set_kind_t kind_of(logic [SET_IDX_W-1:0] set_idx);
      logic [SET_IDX_W-1:0] upper;
      upper = (set_idx >> GROUP_SHIFT) & GROUP_MASK;
      if ((set_idx & GROUP_MASK) == upper) return SET_SRRIP;
      if ((~set_idx & GROUP_MASK) == upper) return SET_BRRIP;
      return SET_FOLLOWER;
    endfunction

    function int unsigned outstanding();
      return owed_outcomes.size();
    endfunction

    // apply one accepted request to the shadow state and queue its outcome
    function void note_request(logic [REQ_W-1:0] code, logic [SET_IDX_W-1:0] set_idx,
                               logic [WAY_IDX_W-1:0] way);
      int                    base;
      logic [1:0]            low;
      logic [1:0]            ins;
      logic [RANK_OUT_W-1:0] mine;
      set_kind_t             kind;
      outcome_t              oc;
      base      = (set_idx % NUM_SETS) * NUM_WAYS;
      kind      = kind_of(set_idx);
      oc.code   = code;
      oc.victim = '0;
      oc.rank   = '0;
      case (code)
        REQ_HIT: begin
          if (way < NUM_WAYS) rrpv_mem[base+way] = RRPV_NEAR;
        end
        REQ_MISS: begin
          // only leader sets move the selector, which saturates at both ends
          if (kind == SET_SRRIP && selector < SELECTOR_MAX - 1) selector++;
          else if (kind == SET_BRRIP && selector > 0) selector--;
        end
        REQ_VICTIM: begin
          // age by the row minimum, then take the lowest way at zero
          low = 2'd3;
          for (int i = 0; i < NUM_WAYS; i++)
            if (rrpv_mem[base+i] < low) low = rrpv_mem[base+i];
          for (int i = 0; i < NUM_WAYS; i++)
            rrpv_mem[base+i] = rrpv_mem[base+i] - low;
          for (int i = NUM_WAYS - 1; i >= 0; i--)
            if (rrpv_mem[base+i] == RRPV_DISTANT) oc.victim = VICTIM_W'(i);
          last_victim = oc.victim;
        end
        REQ_FILL: begin
          if (way < NUM_WAYS) begin
            // brrip inserts long once per bip period, distant otherwise
            if (kind == SET_SRRIP) ins = RRPV_LONG;
            else if (kind == SET_BRRIP || selector >= SELECTOR_MAX / 2)
              ins = (bip_count == 0) ? RRPV_LONG : RRPV_DISTANT;
            else ins = RRPV_LONG;
            rrpv_mem[base+way] = ins;
            bip_count = (bip_count >= BIP_PERIOD - 1) ? 0 : bip_count + 1;
            // newer fills than this way slide one place older
            mine = rank_mem[base+way];
            for (int i = 0; i < NUM_WAYS; i++)
              if (rank_mem[base+i] < mine) rank_mem[base+i]++;
            rank_mem[base+way] = '0;
          end
        end
        REQ_RANK: begin
          oc.rank = (way < NUM_WAYS) ? rank_mem[base+way] : RANK_OUT_W'(NUM_WAYS);
        end
        default: ;
      endcase
      owed_outcomes.push_back(oc);
    endfunction

    // compare one strobed result with the oldest outcome owed
    function void check_result(logic [VICTIM_W-1:0] victim, logic [RANK_OUT_W-1:0] rank);
      outcome_t oc;
      if (owed_outcomes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual victim_way=%0d fill_rank=%0d",
                 $time, victim, rank);
        mismatches++;
        return;
      end
      oc = owed_outcomes.pop_front();
      if (victim !== oc.victim) begin
        $display("%0t: request %0d victim_way: expected %0d, actual %0d",
                 $time, oc.code, oc.victim, victim);
        mismatches++;
      end
      if (rank !== oc.rank) begin
        $display("%0t: request %0d fill_rank: expected %0d, actual %0d",
                 $time, oc.code, oc.rank, rank);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic [REQ_W-1:0]      in_req_type   = '0;
  logic [SET_IDX_W-1:0]  in_set_index  = '0;
  logic [WAY_IDX_W-1:0]  in_way_index  = '0;
  logic                  busy;
  logic                  out_valid;
  logic [VICTIM_W-1:0]   out_victim_way;
  logic [RANK_OUT_W-1:0] out_fill_rank;

  replacement_scoreboard sb = new();
  bit                    no_idle = 1'b0;
  int unsigned           cycle_count = 0;
  logic [SET_IDX_W-1:0]  hot_sets [8];

  drrip_replacement_policy dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_set_index   (in_set_index),
    .in_way_index   (in_way_index),
    .out_valid      (out_valid),
    .out_victim_way (out_victim_way),
    .out_fill_rank  (out_fill_rank)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result strobe check
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_victim_way, out_fill_rank);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("drrip_replacement_policy_tb NOT OK");
      $finish;
    end
  end

  // present one request after a random gap and hold it until accepted
  task automatic issue_request(logic [REQ_W-1:0] code, logic [SET_IDX_W-1:0] set_idx,
                               logic [WAY_IDX_W-1:0] way);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= code;
    in_set_index <= set_idx;
    in_way_index <= way;
    do @(posedge clk); while (busy);
    sb.note_request(code, set_idx, way);
  endtask

  // stop sending until every owed result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // a random leader set of the given flavor
  function automatic logic [SET_IDX_W-1:0] leader_set(bit srrip);
    logic [SET_IDX_W-1:0] upper;
    upper = SET_IDX_W'($urandom_range(0, GROUP - 1));
    return srrip ? ((upper << GROUP_SHIFT) | upper)
                 : ((upper << GROUP_SHIFT) | (~upper & GROUP_MASK));
  endfunction

  // mostly a small pool of sets so rows fill up, sometimes any set
  function automatic logic [SET_IDX_W-1:0] busy_set();
    if ($urandom_range(0, 4) != 0) return hot_sets[$urandom_range(0, 7)];
    return SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
  endfunction

  initial begin
    int                   done;
    int                   pick;
    bit                   sweep_up;
    bit                   seen_top;
    bit                   seen_bottom;
    logic [SET_IDX_W-1:0] s;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: untouched rows, leaders of both flavors, a follower, ranks
    issue_request(REQ_RANK, 0, 0);
    issue_request(REQ_RANK, 1023, 15);
    issue_request(REQ_VICTIM, 5, 0);
    issue_request(REQ_HIT, 1023, 15);
    issue_request(REQ_VICTIM, 1023, 9);
    issue_request(REQ_FILL, 0, 0);
    issue_request(REQ_FILL, 0, 15);
    issue_request(REQ_RANK, 0, 0);
    issue_request(REQ_RANK, 0, 15);
    issue_request(REQ_MISS, 0, 0);
    issue_request(REQ_MISS, 992, 0);
    issue_request(REQ_MISS, 31, 0);
    issue_request(REQ_MISS, 1, 0);
    issue_request(REQ_FILL, 31, 3);
    issue_request(REQ_FILL, 2, 7);
    issue_request(REQ_HIT, 0, 0);
    issue_request(REQ_HIT, 0, 15);
    issue_request(REQ_VICTIM, 0, 0);
    issue_request(REQ_FILL, 0, 0);
    issue_request(REQ_RANK, 0, 15);
    issue_request(REQ_RANK, 2, 8);
    issue_request(REQ_VICTIM, 1023, 0);
    wait_for_results();

    // hot pool: three leaders of each flavor and two followers
    for (int i = 0; i < 6; i++) hot_sets[i] = leader_set(i < 3);
    for (int i = 6; i < 8; i++) begin
      do s = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
      while (sb.kind_of(s) != SET_FOLLOWER);
      hot_sets[i] = s;
    end

    // random: miss-heavy until the selector has hit both limits
    done        = 0;
    sweep_up    = 1'b1;
    seen_top    = 1'b0;
    seen_bottom = 1'b0;
    while ((done < RANDOM_ITEMS || !(seen_top && seen_bottom)) && done < RANDOM_CAP) begin
      if (done % 100 < 3) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 199) == 0) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < ((seen_top && seen_bottom) ? 30 : 90)) begin
        s = ($urandom_range(0, 19) != 0) ? leader_set(sweep_up)
                                         : SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
        issue_request(REQ_MISS, s, WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1)));
        done++;
      end else if (pick < 96) begin
        // victim query followed by a fill of the chosen way
        s = busy_set();
        issue_request(REQ_VICTIM, s, WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1)));
        issue_request(REQ_FILL, s, sb.last_victim);
        done += 2;
        if ($urandom_range(0, 1) == 1) begin
          issue_request(REQ_RANK, s, WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1)));
          done++;
        end
      end else begin
        pick = $urandom_range(0, 2);
        if (pick == 0)
          issue_request(REQ_HIT, busy_set(), WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1)));
        else if (pick == 1)
          issue_request(REQ_FILL, busy_set(), WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1)));
        else
          issue_request(REQ_RANK, busy_set(), WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1)));
        done++;
      end
      // turn the sweep around a little after each limit
      if (sb.selector == SELECTOR_MAX - 1) begin
        if (seen_top) sweep_up = 1'b0;
        seen_top = 1'b1;
      end
      if (sb.selector == 0) begin
        if (seen_bottom) sweep_up = 1'b1;
        seen_bottom = 1'b1;
      end
    end

    // drain and let any late strobe show up
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("drrip_replacement_policy_tb OK");
    end else begin
      $display("drrip_replacement_policy_tb NOT OK");
    end
    $finish;
  end

endmodule
